FILE: sv/wgns_pkg.sv
package wgns_pkg;

   localparam int BINS_DEFAULT = 240;

   localparam logic [31:0] W_OLD      = 32'd858993459;
   localparam logic [31:0] W_NEW      = 32'd214748365;
   localparam logic [31:0] N_OLD      = 32'd1063004406;
   localparam logic [31:0] N_NEW      = 32'd10737418;
   localparam logic [31:0] NOISE_INIT = 32'd2147484;
   localparam logic [63:0] POW_FLOOR  = 64'd4611686018428;
   localparam logic [47:0] ACC_MAX    = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_SMOOTH,
      ST_POWER,
      ST_DIVIDE,
      ST_SQRT,
      ST_GAIN,
      ST_APPLY,
      ST_UPDATE,
      ST_VADSQRT,
      ST_OUTPUT
   } state_type;

endpackage

FILE: sv/wiener_gain_noise_suppressor_unit.sv
// Wiener-gain noise suppressor. Each input transfer carries a pair of Q1.15
// samples; their sum forms the value of one bin, named by an internal
// counter that wraps every BINS transfers (one frame). The bin value is
// smoothed against the stored value, scaled by the Wiener gain g^1.5 derived
// from the bin's noise estimate, written back, and emitted as one output
// transfer whose tlast marks the last bin of a frame. On that last bin the
// tuser field carries a voice activity figure derived from the frame energy.
// Both per-bin stores live in single-port synchronous memories read once and
// written once per item. The time from one input transfer to the earliest
// next one is set mainly by the 32-step bit-serial divider and the 32-step
// square root, which share one iterative unit; the last bin of a frame adds
// the 16-step voice activity root. When the noise estimate is at or above the
// signal power the gain is zero and both iterative steps are skipped; a gain
// of exactly one skips the root. After reset a clearing pass over all BINS
// entries initialises both memories before the first input transfer is taken.
// The finished result moves into an output register, so the next item can be
// taken while that result waits; an item that finishes while the register is
// still full waits for it to empty.
module wiener_gain_noise_suppressor_unit #(
   parameter int BINS = wgns_pkg::BINS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_even, [31:16] sample_odd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_sample
   output logic        rsp_tlast,   // last_of_frame
   output logic [15:0] rsp_tuser    // [15:0] voice_prob
);

   localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

   wgns_pkg::state_type state_ff, state_in;

   // Per-bin memories, single port, registered read.
   logic signed [31:0] smooth_mem [BINS];
   logic [31:0]        noise_mem  [BINS];
   logic signed [31:0] smooth_rd_ff;
   logic [31:0]        noise_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic signed [31:0] smooth_wd;
   logic [31:0]        noise_wd;

   logic [AW-1:0]      bin_ff, bin_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [47:0]        energy_ff, energy_in;
   logic signed [16:0] pair_ff, pair_in;
   logic signed [31:0] s_ff, s_in;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        quo_ff, quo_in;
   logic [5:0]         step_ff, step_in;
   logic [32:0]        g_ff, g_in;
   logic [63:0]        root_ff, root_in;
   logic [63:0]        bit_ff, bit_in;
   logic [32:0]        gain_ff, gain_in;
   logic signed [31:0] sv_ff, sv_in;
   logic [15:0]        out_ff, out_in;
   logic               last_ff, last_in;
   logic               olast_ff, olast_in;
   logic [15:0]        vad_ff, vad_in;
   logic               ovalid_ff, ovalid_in;

   // Datapath temporaries.
   logic signed [63:0] t_smooth;
   logic signed [33:0] t_floor;
   logic [31:0]        mag_s;
   logic [63:0]        sq_s, sq_n;
   logic [64:0]        rem_sh;
   logic [63:0]        sq_try;
   logic [64:0]        gr_prod;
   logic [64:0]        pm_prod;
   logic [32:0]        pm;
   logic [63:0]        nn_sum;
   logic signed [32:0] o_wide;
   logic signed [15:0] o_val;
   logic [31:0]        o_sq;
   logic [47:0]        e_add;
   logic [48:0]        e_sum;
   logic [63:0]        vad_num;
   logic [15:0]        vad_try;
   logic [31:0]        vad_sq;
   logic [47:0]        vad_lhs;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         smooth_mem[mem_addr] <= smooth_wd;
         noise_mem[mem_addr]  <= noise_wd;
      end
      smooth_rd_ff <= smooth_mem[mem_addr];
      noise_rd_ff  <= noise_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wgns_pkg::ST_CLEAR;
         bin_ff    <= '0;
         clr_ff    <= '0;
         energy_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bin_ff    <= bin_in;
         clr_ff    <= clr_in;
         energy_ff <= energy_in;
         ovalid_ff <= ovalid_in;
      end
      pair_ff  <= pair_in;
      s_ff     <= s_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      g_ff     <= g_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      gain_ff  <= gain_in;
      sv_ff    <= sv_in;
      out_ff   <= out_in;
      last_ff  <= last_in;
      olast_ff <= olast_in;
      vad_ff   <= vad_in;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wgns_pkg::ST_CLEAR:
            if (clr_ff == LAST_BIN) state_in = wgns_pkg::ST_IDLE;
         wgns_pkg::ST_IDLE:
            if (req_tvalid) state_in = wgns_pkg::ST_READ;
         wgns_pkg::ST_READ:   state_in = wgns_pkg::ST_SMOOTH;
         wgns_pkg::ST_SMOOTH: state_in = wgns_pkg::ST_POWER;
         wgns_pkg::ST_POWER:
            state_in = (sq_n >= den_in) ? wgns_pkg::ST_GAIN : wgns_pkg::ST_DIVIDE;
         wgns_pkg::ST_DIVIDE:
            if (step_ff == 6'd31) state_in = wgns_pkg::ST_SQRT;
         wgns_pkg::ST_SQRT:
            if (bit_ff == 64'd0 || g_ff[32]) state_in = wgns_pkg::ST_GAIN;
         wgns_pkg::ST_GAIN:   state_in = wgns_pkg::ST_APPLY;
         wgns_pkg::ST_APPLY:  state_in = wgns_pkg::ST_UPDATE;
         wgns_pkg::ST_UPDATE:
            state_in = last_ff ? wgns_pkg::ST_VADSQRT : wgns_pkg::ST_OUTPUT;
         wgns_pkg::ST_VADSQRT:
            if (bit_ff == 64'd0) state_in = wgns_pkg::ST_OUTPUT;
         wgns_pkg::ST_OUTPUT:
            if (!ovalid_ff || rsp_tready) state_in = wgns_pkg::ST_IDLE;
         default:             state_in = wgns_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      bin_in    = bin_ff;
      clr_in    = clr_ff;
      energy_in = energy_ff;
      pair_in   = pair_ff;
      s_in      = s_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      g_in      = g_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      gain_in   = gain_ff;
      sv_in     = sv_ff;
      out_in    = out_ff;
      last_in   = last_ff;
      olast_in  = olast_ff;
      vad_in    = vad_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      mem_we    = 1'b0;
      mem_addr  = bin_ff;
      smooth_wd = sv_ff;
      noise_wd  = 32'd0;
      req_tready = (state_ff == wgns_pkg::ST_IDLE);

      t_smooth = 64'(signed'(wgns_pkg::W_OLD)) * 64'(smooth_rd_ff)
               + 64'(signed'(wgns_pkg::W_NEW)) * (64'(pair_ff) <<< 15)
               + 64'sd536870912;
      t_floor  = t_smooth[63:30];
      mag_s    = s_ff[31] ? 32'(-33'(s_ff)) : 32'(s_ff);
      sq_s     = 64'(mag_s) * 64'(mag_s);
      sq_n     = 64'(noise_rd_ff) * 64'(noise_rd_ff);
      rem_sh   = {rem_ff, 1'b0};
      sq_try   = root_ff + bit_ff;
      gr_prod  = 65'(g_ff[31:0]) * 65'(root_ff[32:0]) + 65'd2147483648;
      pm_prod  = 65'(mag_s) * 65'(gain_ff) + 65'd2147483648;
      pm       = pm_prod[64:32];
      nn_sum   = 64'(wgns_pkg::N_OLD) * 64'(noise_rd_ff) + 64'(wgns_pkg::N_NEW) *
                 64'(sv_ff[31] ? 32'(-33'(sv_ff)) : 32'(sv_ff)) + 64'd536870912;
      o_wide   = (33'(sv_ff) + 33'sd32768) >>> 16;
      o_val    = (o_wide > 33'sd32767) ? 16'sh7FFF :
                 ((o_wide < -33'sd32768) ? 16'sh8000 : o_wide[15:0]);
      o_sq     = 32'(signed'(o_val) * signed'(o_val));
      e_add    = {15'd0, o_sq, 1'b0};
      e_sum    = 49'(energy_ff) + 49'(e_add);
      vad_num  = 64'(energy_ff) * 64'd200;
      vad_try  = root_ff[15:0] | bit_ff[15:0];
      vad_sq   = 32'(vad_try) * 32'(vad_try);
      vad_lhs  = 48'(vad_sq) * 48'(BINS);

      case (state_ff)
         wgns_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            smooth_wd = 32'sd0;
            noise_wd  = wgns_pkg::NOISE_INIT;
            clr_in    = clr_ff + AW'(1);
         end
         wgns_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               pair_in = 17'(signed'(req_tdata[15:0])) + 17'(signed'(req_tdata[31:16]));
               last_in = (bin_ff == LAST_BIN);
            end
         end
         wgns_pkg::ST_SMOOTH: begin
            if (t_floor > 34'sd2147483647) s_in = 32'sh7FFFFFFF;
            else if (t_floor < -34'sd2147483648) s_in = 32'sh80000000;
            else s_in = t_floor[31:0];
         end
         wgns_pkg::ST_POWER: begin
            den_in  = (sq_s > wgns_pkg::POW_FLOOR) ? sq_s : wgns_pkg::POW_FLOOR;
            rem_in  = sq_n;
            quo_in  = 64'd0;
            step_in = 6'd0;
            g_in    = 33'd0;
            gain_in = 33'd0;
         end
         wgns_pkg::ST_DIVIDE: begin
            step_in = step_ff + 6'd1;
            if (rem_sh >= 65'(den_ff)) begin
               rem_in = 64'(rem_sh - 65'(den_ff));
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            if (step_ff == 6'd31) begin
               g_in    = 33'h1_0000_0000 - {1'b0, quo_in[31:0]};
               rem_in  = {g_in[31:0], 32'd0};
               root_in = 64'd0;
               bit_in  = 64'h4000_0000_0000_0000;
            end
         end
         wgns_pkg::ST_SQRT: begin
            if (bit_ff != 64'd0) begin
               if (rem_ff >= sq_try) begin
                  rem_in  = rem_ff - sq_try;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         wgns_pkg::ST_GAIN: begin
            if (g_ff[32]) gain_in = 33'h1_0000_0000;
            else if (quo_ff != 64'd0 || g_ff != 33'd0) gain_in = {1'b0, gr_prod[63:32]};
         end
         wgns_pkg::ST_APPLY: begin
            if (s_ff[31]) sv_in = (pm > 33'd2147483648) ? 32'sh80000000 : 32'(-33'(pm));
            else sv_in = (pm > 33'd2147483647) ? 32'sh7FFFFFFF : 32'(pm);
         end
         wgns_pkg::ST_UPDATE: begin
            mem_we    = 1'b1;
            noise_wd  = (nn_sum[63:30] > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : nn_sum[61:30];
            energy_in = e_sum[48] ? wgns_pkg::ACC_MAX : e_sum[47:0];
            bin_in    = last_ff ? '0 : bin_ff + AW'(1);
            if (last_ff) begin
               root_in = 64'd0;
               bit_in  = 64'd32768;
            end
         end
         wgns_pkg::ST_VADSQRT: begin
            // The largest 16-bit root whose square times BINS stays within
            // 200 times the frame energy, one bit a cycle from the top.
            if (bit_ff != 64'd0) begin
               if (64'(vad_lhs) <= vad_num) root_in = {48'd0, vad_try};
               bit_in = bit_ff >> 1;
            end
         end
         wgns_pkg::ST_OUTPUT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               out_in    = o_val;
               olast_in  = last_ff;
               vad_in    = last_ff ? root_ff[15:0] : 16'd0;
               if (last_ff) energy_in = '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = vad_ff;

   // A waiting output transfer keeps its contents until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("output changed while waiting");

   // The memories are written only in the clearing pass or the write-back step.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == wgns_pkg::ST_CLEAR || state_ff == wgns_pkg::ST_UPDATE))
      else $error("unexpected memory write");

   // The voice activity figure is zero except on the last bin of a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == 16'd0))
      else $error("vad outside frame end");

endmodule

FILE: tb/tb_wiener_gain_noise_suppressor_unit.sv
`timescale 1ns / 100ps

module tb_wiener_gain_noise_suppressor_unit;

   localparam int BINS       = wgns_pkg::BINS_DEFAULT;
   localparam int STALL_MAX  = 5000;  // cycles without any transfer before giving up
   localparam int HOLD_LEN   = 800;   // long receiver hold-off, in cycles
   localparam int HOLD_AT    = 900;   // input transfer count that triggers it
   localparam int NONE       = -1;    // no hand-typed expectation for this item

   typedef struct packed {
      logic [15:0] sample;
      logic        last;
      logic [15:0] vad;
   } bin_result_type;

   typedef struct {
      logic [15:0] even;
      logic [15:0] odd;
      int          typed;  // expected out_sample, or NONE
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] sample_even, [31:16] sample_odd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] out_sample
   logic        rsp_tlast;   // last_of_frame
   logic [15:0] rsp_tuser;   // [15:0] voice_prob

   wiener_gain_noise_suppressor_unit #(.BINS(BINS)) DUT (.*);

   // Our own copy of the per-bin stores, the bin counter and the frame energy.
   logic signed [31:0] smooth_mem [BINS];
   logic        [31:0] noise_mem  [BINS];
   int                 bin_idx;
   bit          [63:0] frame_energy;

   bin_result_type pending_bins [$];
   int          typed_q [$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          req_count;
   int          mismatches;
   int          quiet_cycles;

   // The clock runs with a 4 ns period; reset is held at the start.
   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Integer square root, truncated, by the usual bit-pair method.
   function automatic bit [63:0] isqrt(input bit [63:0] v);
      bit [63:0] root;
      bit [63:0] b;
      root = 0;
      b    = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v    = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Wiener gain raised to 1.5, in Q1.32, where 2^32 stands for exactly one.
   function automatic bit [63:0] wiener_gain_q32(input logic signed [31:0] s,
                                                 input logic [31:0] nz);
      bit [63:0] mag, sig_pow, noise_pow, den, rem, quot, g, root;
      mag       = s < 0 ? 64'(-longint'(s)) : 64'(s);
      sig_pow   = mag * mag;
      noise_pow = 64'(nz) * 64'(nz);
      den       = sig_pow > wgns_pkg::POW_FLOOR ? sig_pow : wgns_pkg::POW_FLOOR;
      if (noise_pow >= den) return 0;
      rem  = noise_pow;
      quot = 0;
      for (int i = 0; i < 32; i++) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= den) begin
            rem  = rem - den;
            quot = quot | 64'd1;
         end
      end
      g = (64'd1 << 32) - quot;
      if (g >= (64'd1 << 32)) return 64'd1 << 32;
      root = isqrt(g << 32);
      return (g * root + (64'd1 << 31)) >> 32;
   endfunction

   // Works out the result of one sample pair and advances the predicted state.
   function automatic bin_result_type denoise_pair(input logic [15:0] even,
                                                   input logic [15:0] odd);
      bin_result_type res;
      int          k;
      longint      spec, acc, sv, o;
      logic signed [31:0] s;
      bit [63:0]   g, pm, nn, e;
      k    = bin_idx < BINS ? bin_idx : 0;
      spec = (longint'($signed(even)) + longint'($signed(odd))) * 32768;
      acc  = longint'(wgns_pkg::W_OLD) * longint'(smooth_mem[k])
             + longint'(wgns_pkg::W_NEW) * spec + (longint'(1) << 29);
      acc  = acc >>> 30;
      if (acc > 32'sh7FFF_FFFF) acc = 32'sh7FFF_FFFF;
      if (acc < -(longint'(1) << 31)) acc = -(longint'(1) << 31);
      s  = acc[31:0];
      g  = wiener_gain_q32(s, noise_mem[k]);
      pm = s < 0 ? 64'(-longint'(s)) : 64'(s);
      pm = (pm * g + (64'd1 << 31)) >> 32;
      sv = s < 0 ? -longint'(pm) : longint'(pm);
      if (sv > 32'sh7FFF_FFFF) sv = 32'sh7FFF_FFFF;
      if (sv < -(longint'(1) << 31)) sv = -(longint'(1) << 31);
      smooth_mem[k] = sv[31:0];
      pm = sv < 0 ? 64'(-sv) : 64'(sv);
      nn = (64'(wgns_pkg::N_OLD) * 64'(noise_mem[k]) + 64'(wgns_pkg::N_NEW) * pm
            + (64'd1 << 29)) >> 30;
      noise_mem[k] = nn > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : nn[31:0];
      o = (sv + 32768) >>> 16;
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      e = 64'(2 * o * o);
      // The frame energy saturates at the top of its 48 bits.
      frame_energy = (frame_energy > 64'(wgns_pkg::ACC_MAX) - e) ?
                     64'(wgns_pkg::ACC_MAX) : frame_energy + e;
      res.sample = o[15:0];
      res.last   = (k == BINS - 1);
      res.vad    = '0;
      if (res.last) begin
         nn           = isqrt((frame_energy * 200) / BINS);
         res.vad      = nn > 65535 ? 16'hFFFF : nn[15:0];
         frame_energy = 0;
         bin_idx      = 0;
      end else begin
         bin_idx = k + 1;
      end
      return res;
   endfunction

   // Every accepted input transfer is predicted at once; a hand-typed value, where
   // the stimulus row carries one, stands in for the predicted out_sample.
   always @(posedge clock) begin
      bin_result_type r;
      int          t;
      if (!reset && req_tvalid && req_tready) begin
         r = denoise_pair(req_tdata[15:0], req_tdata[31:16]);
         t = typed_q.pop_front();
         if (t != NONE) r.sample = t[15:0];
         pending_bins.push_back(r);
         req_count++;
      end
   end

   // Each output transfer is checked against the oldest outstanding bin result.
   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output transfer: sample %h last %b vad %h",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_bins.pop_front();
            if (rsp_tdata !== want.sample || rsp_tlast !== want.last ||
                rsp_tuser !== want.vad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("bin mismatch: expected sample %h last %b vad %h, got %h %b %h",
                           want.sample, want.last, want.vad,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // The receiver stalls at random, and once, part way through the run, holds off
   // for a long stretch so that the output register stays full and the input
   // backs up while the sender keeps offering pairs.
   initial begin
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && req_count >= HOLD_AT) begin
            held       = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: the run is abandoned when no transfer of either kind takes place
   // for too long. The limit covers the clearing pass after reset as well.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offers one pair, idling first at random, and returns at the falling edge
   // after the transfer; tvalid stays high if the next pair follows straight on.
   task automatic offer_pair(input logic [15:0] even, input logic [15:0] odd,
                             input int typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      typed_q.push_back(typed);
      req_tvalid <= 1'b1;
      req_tdata  <= {odd, even};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random pair of one of several characters: full-scale noise, quiet signal,
   // loud signal pinned near the rails, or silence.
   task automatic offer_random_pair();
      logic [15:0] e, o;
      case ($urandom_range(9))
         0, 1, 2: begin
            e = 16'($urandom());
            o = 16'($urandom());
         end
         3, 4, 5, 6: begin
            e = 16'($signed($urandom_range(512)) - 256);
            o = 16'($signed($urandom_range(512)) - 256);
         end
         7, 8: begin
            e = $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(64)) :
                                    16'h8000 + 16'($urandom_range(64));
            o = $urandom_range(1) ? e : 16'h7FFF - 16'($urandom_range(2048));
         end
         default: begin
            e = '0;
            o = '0;
         end
      endcase
      offer_pair(e, o, NONE);
   endtask

   // Directed pairs: silence after reset gives silence out, then the rails of both
   // samples in every combination, single-bit values and cancelling pairs.
   stim_row_type directed_rows [20] = '{
      '{16'h0000, 16'h0000, 0},
      '{16'h0000, 16'h0000, 0},
      '{16'h7FFF, 16'h7FFF, NONE},
      '{16'h8000, 16'h8000, NONE},
      '{16'h7FFF, 16'h8000, NONE},
      '{16'h8000, 16'h7FFF, NONE},
      '{16'h0001, 16'h0000, NONE},
      '{16'hFFFF, 16'h0000, NONE},
      '{16'h0000, 16'hFFFF, NONE},
      '{16'h5555, 16'hAAAA, NONE},
      '{16'hAAAA, 16'h5555, NONE},
      '{16'h4000, 16'h4000, NONE},
      '{16'hC000, 16'hC000, NONE},
      '{16'h1234, 16'hEDCC, NONE},
      '{16'h7FFF, 16'h7FFF, NONE},
      '{16'h7FFF, 16'h7FFF, NONE},
      '{16'h8000, 16'h8000, NONE},
      '{16'h0000, 16'h0000, NONE},
      '{16'h0100, 16'h00FF, NONE},
      '{16'hFF00, 16'hFF01, NONE}
   };

   initial begin
      for (int i = 0; i < BINS; i++) begin
         smooth_mem[i] = '0;
         noise_mem[i]  = wgns_pkg::NOISE_INIT;
      end
      bin_idx        = 0;
      frame_energy   = 0;
      req_count      = 0;
      mismatches     = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table first, with neither side idling.
      foreach (directed_rows[i])
         offer_pair(directed_rows[i].even, directed_rows[i].odd, directed_rows[i].typed);

      // Random pairs in four idling phases; the long receiver hold-off falls in
      // the third, where the sender is otherwise never idle.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         repeat (400) offer_random_pair();
      end
      req_tvalid <= 1'b0;

      while (pending_bins.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/wgns_pkg.sv
sv/wiener_gain_noise_suppressor_unit.sv
tb/tb_wiener_gain_noise_suppressor_unit.sv
